FILE: sv/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types, codes and widths of the animation frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

	localparam int ACTION_W   = 3;
	localparam int TIME_W     = 64;
	localparam int FRAME_W    = 16;
	localparam int SPEED_W    = 8;
	localparam int PERIOD_W   = 24;
	localparam int PROGRESS_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// shared divider: 32-bit dividend, 16-bit divisor, two quotient bits a cycle
	localparam int DIV_N_W   = 32;
	localparam int DIV_D_W   = 16;
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_PAIRS_PERIOD = 5'd16;
	localparam logic [DIV_CNT_W-1:0] DIV_PAIRS_PROG   = 5'd4;

	localparam logic [PROGRESS_W-1:0] PROGRESS_FULL = 7'd100;
	localparam logic [6:0]            PERCENT_MUL   = 7'd100;
	localparam logic [SPEED_W-1:0]    SPEED_RESET   = 8'd128;

	localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PAUSE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SEEK  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd3;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_PLAYING = 2'd1,
		MODE_LOOPING = 2'd2,
		MODE_PAUSED  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PERIOD,
		ST_COMPARE,
		ST_PRODUCT,
		ST_PROG_GO,
		ST_PROG,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;      // latch the input beat, clear flags
		logic start_period; // latch elapsed time, start period division
		logic apply_cmd;    // apply a non-timed command
		logic apply_tick;   // compare and advance the frame
		logic calc_product; // frame*100, saturation flag
		logic start_prog;   // start progress division
		logic load_out;     // load the result register
	} afs_cmd_t;

	typedef struct packed {
		logic tick_run;  // tick while playing or looping
		logic div_busy;
		logic prog_skip; // progress known without division
		logic out_free;
	} afs_status_t;

endpackage

FILE: sv/afs_in_if.sv
// ----------------------------------------------------------------------------
// afs_in_if
// Command channel: valid/ready handshake with action, timestamp and seek frame.
// ----------------------------------------------------------------------------
interface afs_in_if;
	logic                           valid;
	logic                           ready;
	logic [afs_pkg::ACTION_W-1:0]   action;
	logic [afs_pkg::TIME_W-1:0]     time_us;
	logic [afs_pkg::FRAME_W-1:0]    seek_frame;

	modport source (output valid, action, time_us, seek_frame, input ready);
	modport sink   (input valid, action, time_us, seek_frame, output ready);
endinterface

FILE: sv/afs_out_if.sv
// ----------------------------------------------------------------------------
// afs_out_if
// Result channel: valid/ready handshake with state, frame, flags and progress.
// ----------------------------------------------------------------------------
interface afs_out_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      play_status;
	logic [afs_pkg::FRAME_W-1:0]     frame_pos;
	logic                            frame_advanced;
	logic                            completed;
	logic                            rejected;
	logic [afs_pkg::PROGRESS_W-1:0]  progress_percent;

	modport source (output valid, play_status, frame_pos, frame_advanced, completed,
		rejected, progress_percent, input ready);
	modport sink   (input valid, play_status, frame_pos, frame_advanced, completed,
		rejected, progress_percent, output ready);
endinterface

FILE: sv/afs_div.sv
// ----------------------------------------------------------------------------
// afs_div
// Restoring unsigned divider, two quotient bits per cycle, preloadable remainder.
// ----------------------------------------------------------------------------
module afs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [afs_pkg::DIV_N_W-1:0]       dividend,
	input  logic [afs_pkg::DIV_D_W-1:0]       rem_init,
	input  logic [afs_pkg::DIV_D_W-1:0]       divisor,
	input  logic [afs_pkg::DIV_CNT_W-1:0]     pairs,
	output logic                              busy,
	output logic [afs_pkg::DIV_N_W-1:0]       quotient
);
	import afs_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   div_q;
	logic [DIV_N_W-1:0]   quo_q;

	logic [DIV_D_W:0]     r1, r2, dext;
	logic                 q1, q2;
	logic [DIV_D_W-1:0]   rem1, rem2;
	logic [DIV_D_W:0]     diff1, diff2;

	always_comb begin
		dext  = {1'b0, div_q};
		r1    = {rem_q, quo_q[DIV_N_W-1]};
		q1    = (r1 >= dext);
		diff1 = r1 - dext;
		rem1  = q1 ? diff1[DIV_D_W-1:0] : r1[DIV_D_W-1:0];
		r2    = {rem1, quo_q[DIV_N_W-2]};
		q2    = (r2 >= dext);
		diff2 = r2 - dext;
		rem2  = q2 ? diff2[DIV_D_W-1:0] : r2[DIV_D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= pairs;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem2;
			quo_q <= {quo_q[DIV_N_W-3:0], q1, q2};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: sv/afs_ctrl.sv
// ----------------------------------------------------------------------------
// afs_ctrl
// Sequencer state machine: orders capture, timing, update, progress and output.
// ----------------------------------------------------------------------------
module afs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  afs_pkg::afs_status_t  status,
	output afs_pkg::afs_cmd_t     cmd
);
	import afs_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = status.tick_run ? ST_PERIOD : ST_PRODUCT;
			end
			ST_PERIOD: begin
				if (!status.div_busy) state_d = ST_COMPARE;
			end
			ST_COMPARE: state_d = ST_PRODUCT;
			ST_PRODUCT: state_d = ST_PROG_GO;
			ST_PROG_GO: begin
				state_d = status.prog_skip ? ST_DONE : ST_PROG;
			end
			ST_PROG: begin
				if (!status.div_busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DECODE: begin
				cmd.start_period = status.tick_run;
				cmd.apply_cmd    = !status.tick_run;
			end
			ST_COMPARE: cmd.apply_tick   = 1'b1;
			ST_PRODUCT: cmd.calc_product = 1'b1;
			ST_PROG_GO: cmd.start_prog   = !status.prog_skip;
			ST_DONE:    cmd.load_out     = status.out_free;
			default: ;
		endcase
	end

endmodule

FILE: sv/afs_datapath.sv
// ----------------------------------------------------------------------------
// afs_datapath
// Configuration, play state, elapsed-time check, progress and result register.
// ----------------------------------------------------------------------------
module afs_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  afs_pkg::afs_cmd_t                  cmd,
	output afs_pkg::afs_status_t               status,
	input  logic                               cfg_we,
	input  logic [afs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [afs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [afs_pkg::ACTION_W-1:0]       in_action,
	input  logic [afs_pkg::TIME_W-1:0]         in_time_us,
	input  logic [afs_pkg::FRAME_W-1:0]        in_seek_frame,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         out_play_status,
	output logic [afs_pkg::FRAME_W-1:0]        out_frame_pos,
	output logic                               out_frame_advanced,
	output logic                               out_completed,
	output logic                               out_rejected,
	output logic [afs_pkg::PROGRESS_W-1:0]     out_progress_percent
);
	import afs_pkg::*;

	// configuration
	logic                loop_en_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [FRAME_W-1:0]  total_q;
	logic [PERIOD_W-1:0] period_cfg_q;

	// play state
	mode_t               mode_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [TIME_W-1:0]   last_q;

	// item in flight
	logic [ACTION_W-1:0] action_q;
	logic [TIME_W-1:0]   time_q;
	logic [FRAME_W-1:0]  seek_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic                adv_q, done_q, rej_q;
	logic [22:0]         prod_q;
	logic                sat_q;

	// result register
	logic                      out_valid_q;
	mode_t                     out_mode_q;
	logic [FRAME_W-1:0]        out_frame_q;
	logic                      out_adv_q, out_done_q, out_rej_q;
	logic [PROGRESS_W-1:0]     out_prog_q;

	// divider hookup
	logic                 div_start;
	logic [DIV_N_W-1:0]   div_dividend;
	logic [DIV_D_W-1:0]   div_rem_init;
	logic [DIV_D_W-1:0]   div_divisor;
	logic [DIV_CNT_W-1:0] div_pairs;
	logic                 div_busy;
	logic [DIV_N_W-1:0]   div_quo;

	logic [SPEED_W-1:0]   speed_eff;
	logic                 running;
	logic                 due;
	logic [FRAME_W:0]     next_frame;
	logic [PROGRESS_W-1:0] prog_val;

	assign speed_eff = (speed_q == '0) ? SPEED_W'(1) : speed_q;
	assign running   = (mode_q == MODE_PLAYING) || (mode_q == MODE_LOOPING);

	always_comb begin
		div_start    = cmd.start_period || cmd.start_prog;
		if (cmd.start_period) begin
			div_dividend = {period_cfg_q, 8'd0};
			div_rem_init = '0;
			div_divisor  = DIV_D_W'(speed_eff);
			div_pairs    = DIV_PAIRS_PERIOD;
		end else begin
			// quotient fits in 8 bits, so seed the remainder with the upper bits
			div_dividend = {prod_q[7:0], 24'd0};
			div_rem_init = DIV_D_W'(prod_q[22:8]);
			div_divisor  = total_q;
			div_pairs    = DIV_PAIRS_PROG;
		end
	end

	afs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.rem_init (div_rem_init),
		.divisor  (div_divisor),
		.pairs    (div_pairs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign due        = (elapsed_q[63:32] != '0) || (elapsed_q[31:0] >= div_quo);
	assign next_frame = {1'b0, frame_q} + 1'b1;

	assign status.tick_run  = (action_q == ACT_TICK) && running;
	assign status.div_busy  = div_busy;
	assign status.prog_skip = sat_q;
	assign status.out_free  = !out_valid_q || out_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_en_q    <= 1'b0;
			speed_q      <= SPEED_RESET;
			total_q      <= '0;
			period_cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOOP_ENABLE: loop_en_q    <= cfg_wdata[0];
				REG_SPEED:       speed_q      <= cfg_wdata[SPEED_W-1:0];
				REG_FRAME_TOTAL: total_q      <= cfg_wdata[FRAME_W-1:0];
				REG_PERIOD:      period_cfg_q <= cfg_wdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// play state and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STOPPED;
			frame_q <= '0;
			last_q  <= '0;
			adv_q   <= 1'b0;
			done_q  <= 1'b0;
			rej_q   <= 1'b0;
		end else if (cmd.capture) begin
			adv_q  <= 1'b0;
			done_q <= 1'b0;
			rej_q  <= 1'b0;
		end else if (cmd.apply_cmd) begin
			unique case (action_q)
				ACT_START: begin
					mode_q  <= loop_en_q ? MODE_LOOPING : MODE_PLAYING;
					frame_q <= '0;
					last_q  <= time_q;
				end
				ACT_PAUSE: begin
					if (mode_q == MODE_STOPPED) rej_q <= 1'b1;
					else                         mode_q <= MODE_PAUSED;
				end
				ACT_STOP: begin
					mode_q  <= MODE_STOPPED;
					frame_q <= '0;
				end
				ACT_SEEK: frame_q <= seek_q;
				default: ;
			endcase
		end else if (cmd.apply_tick && due) begin
			last_q <= time_q;
			if (next_frame >= {1'b0, total_q}) begin
				if (loop_en_q) begin
					frame_q <= '0;
					adv_q   <= 1'b1;
				end else begin
					// an empty animation stops on frame 0
					frame_q <= (total_q == '0) ? '0 : total_q - 1'b1;
					mode_q  <= MODE_STOPPED;
					done_q  <= 1'b1;
				end
			end else begin
				frame_q <= next_frame[FRAME_W-1:0];
				adv_q   <= 1'b1;
			end
		end
	end

	// item payload and scratch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			time_q   <= in_time_us;
			seek_q   <= in_seek_frame;
		end
		if (cmd.start_period) begin
			elapsed_q <= time_q - last_q;
		end
		if (cmd.calc_product) begin
			prod_q <= 23'(frame_q) * 23'(PERCENT_MUL);
			sat_q  <= (frame_q >= total_q);
		end
	end

	// progress: empty gives 0, at or past the end gives 100
	always_comb begin
		if (total_q == '0)  prog_val = '0;
		else if (sat_q)     prog_val = PROGRESS_FULL;
		else                prog_val = div_quo[PROGRESS_W-1:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_mode_q  <= mode_q;
			out_frame_q <= frame_q;
			out_adv_q   <= adv_q;
			out_done_q  <= done_q;
			out_rej_q   <= rej_q;
			out_prog_q  <= prog_val;
		end
	end

	assign out_valid            = out_valid_q;
	assign out_play_status      = out_mode_q;
	assign out_frame_pos        = out_frame_q;
	assign out_frame_advanced   = out_adv_q;
	assign out_completed        = out_done_q;
	assign out_rejected         = out_rej_q;
	assign out_progress_percent = out_prog_q;

endmodule

FILE: sv/animation_frame_sequencer_core.sv
// ----------------------------------------------------------------------------
// animation_frame_sequencer_core
// Frame sequencer for a frame-sequence animation, one result beat per command.
// ----------------------------------------------------------------------------
// Each command beat (tick, start, pause, stop, seek, with a microsecond
// timestamp) yields exactly one result beat carrying the play state, the
// current frame, the advanced/completed/rejected flags and the progress in
// percent. Commands are handled one at a time. A tick while playing or
// looping computes the frame period frame_period_us*256/speed_factor anew
// on a shared two-bits-per-cycle divider, then progress takes another pass
// of the same divider. Other commands skip the period pass; progress past
// the last frame, or with no frames, skips the divider too. A result beat
// held on the output stalls the next command in its final state until the
// output is free. The result register lets the next command be accepted
// while a result beat still waits on the output. Configuration writes are
// taken any time but must only be issued while the block is idle. No
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	afs_in_if.sink                         in_ch,
	afs_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [afs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [afs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import afs_pkg::*;

	afs_cmd_t    cmd;
	afs_status_t status;

	// sequencer: accepts a beat only from idle, then walks the datapath
	afs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: registers, state update, divider, result register
	afs_datapath u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_wdata            (cfg_wdata),
		.in_action            (in_ch.action),
		.in_time_us           (in_ch.time_us),
		.in_seek_frame        (in_ch.seek_frame),
		.out_valid            (out_ch.valid),
		.out_ready            (out_ch.ready),
		.out_play_status      (out_ch.play_status),
		.out_frame_pos        (out_ch.frame_pos),
		.out_frame_advanced   (out_ch.frame_advanced),
		.out_completed        (out_ch.completed),
		.out_rejected         (out_ch.rejected),
		.out_progress_percent (out_ch.progress_percent)
	);

endmodule

FILE: tb/sv/tb_animation_frame_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_animation_frame_sequencer_core
// Self-checking regression of the animation frame sequencer core.
// ----------------------------------------------------------------------------
// A shadow copy of the sequencer (play mode, frame, last advance stamp and
// the four registers) predicts one result beat per accepted command beat.
// A receiver process pops the oldest prediction for every result beat and
// compares it field by field. Directed cases cover the reset defaults, the
// empty animation, the last-frame stop and wrap, a zero speed factor, stamp
// wrap-around, seeks past the end and the undefined actions. Random phases
// then reprogram the registers and play well-formed start/tick sequences
// with tick stamps placed on and around the frame period, mixed with seeks,
// pauses, stops, restarts, undefined actions and stray stamps. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_animation_frame_sequencer_core;
	import afs_pkg::*;

	localparam int LIMIT_CYCLES  = 1000000;
	localparam int SETTLE_CYCLES = 32;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_BEATS   = 95;

	localparam logic [FRAME_W-1:0]  FRAME_LAST = '1;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
	localparam logic [TIME_W-1:0]   WRAP_BASE  = 64'hFFFF_FFFF_FFFF_FFF0;

	// One expected result beat.
	typedef struct packed {
		mode_t                 status;
		logic [FRAME_W-1:0]    frame;
		logic                  advanced;
		logic                  done;
		logic                  rejected;
		logic [PROGRESS_W-1:0] percent;
	} seq_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	afs_in_if  cmd_ch ();
	afs_out_if res_ch ();

	animation_frame_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (cmd_ch),
		.out_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow registers and play state of the sequencer.
	logic                 shadow_loop   = 1'b0;
	logic [SPEED_W-1:0]   shadow_speed  = SPEED_RESET;
	logic [FRAME_W-1:0]   shadow_total  = '0;
	logic [PERIOD_W-1:0]  shadow_period = '0;
	mode_t                shadow_mode   = MODE_STOPPED;
	logic [FRAME_W-1:0]   shadow_frame  = '0;
	logic [TIME_W-1:0]    shadow_last   = '0;

	seq_result_t pending_results[$];

	int  cmd_count      = 0;
	int  result_count   = 0;
	int  advance_count  = 0;
	int  complete_count = 0;
	int  reject_count   = 0;
	int  error_count    = 0;
	int  cycle_count    = 0;
	bit  tx_quiet       = 1'b0;
	bit  rx_quiet       = 1'b0;

	// Free-running 2 ns clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: give up on a hang well past the slowest legal run.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: watchdog expired, %0d result beats outstanding", $time,
			pending_results.size());
		$display("animation_frame_sequencer_core regression: fail");
		$finish;
	end

	// Frame period in microseconds at the current speed; zero speed counts as one.
	function automatic logic [TIME_W-1:0] frame_period_ticks();
		logic [TIME_W-1:0] num;
		logic [TIME_W-1:0] den;
		num = TIME_W'(shadow_period) << 8;
		den = (shadow_speed == '0) ? 64'd1 : TIME_W'(shadow_speed);
		return num / den;
	endfunction

	// Advance the shadow sequencer by one command and return the result it reports.
	function automatic seq_result_t sequence_step(input logic [ACTION_W-1:0] action,
		input logic [TIME_W-1:0] stamp, input logic [FRAME_W-1:0] seek);
		seq_result_t r;
		logic [FRAME_W:0] next_frame;
		logic [31:0]      pct;
		r = '0;
		case (action)
			ACT_TICK: begin
				// Only a running animation reacts, and only once a full period has gone.
				if ((shadow_mode == MODE_PLAYING || shadow_mode == MODE_LOOPING) &&
					(stamp - shadow_last >= frame_period_ticks())) begin
					next_frame  = {1'b0, shadow_frame} + 1'b1;
					shadow_last = stamp;
					if (next_frame >= {1'b0, shadow_total}) begin
						if (shadow_loop) begin
							shadow_frame = '0;
							r.advanced   = 1'b1;
						end else begin
							// Hold the last frame; an empty animation holds frame 0.
							shadow_frame = (shadow_total == '0) ? '0 : shadow_total - 1'b1;
							shadow_mode  = MODE_STOPPED;
							r.done       = 1'b1;
						end
					end else begin
						shadow_frame = next_frame[FRAME_W-1:0];
						r.advanced   = 1'b1;
					end
				end
			end
			ACT_START: begin
				shadow_mode  = shadow_loop ? MODE_LOOPING : MODE_PLAYING;
				shadow_frame = '0;
				shadow_last  = stamp;
			end
			ACT_PAUSE: begin
				if (shadow_mode == MODE_STOPPED)
					r.rejected = 1'b1;
				else
					shadow_mode = MODE_PAUSED;
			end
			ACT_STOP: begin
				shadow_mode  = MODE_STOPPED;
				shadow_frame = '0;
			end
			ACT_SEEK: shadow_frame = seek;
			default: ;
		endcase
		r.status = shadow_mode;
		r.frame  = shadow_frame;
		if (shadow_total == '0)
			pct = '0;
		else
			pct = (32'(shadow_frame) * 32'(PERCENT_MUL)) / 32'(shadow_total);
		if (pct > 32'(PROGRESS_FULL))
			pct = 32'(PROGRESS_FULL);
		r.percent = pct[PROGRESS_W-1:0];
		return r;
	endfunction

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int idle_len(input bit quiet);
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic check_field(input string name, input logic [TIME_W-1:0] want,
		input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// Send one command beat, record its prediction, then idle a while.
	// Valid stays high when no gap follows, so back-to-back beats never
	// see valid dropped and raised in the same step.
	task automatic issue_command(input logic [ACTION_W-1:0] action,
		input logic [TIME_W-1:0] stamp, input logic [FRAME_W-1:0] seek);
		seq_result_t predicted;
		int gap;
		cmd_ch.valid      <= 1'b1;
		cmd_ch.action     <= action;
		cmd_ch.time_us    <= stamp;
		cmd_ch.seek_frame <= seek;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = sequence_step(action, stamp, seek);
		pending_results.push_back(predicted);
		cmd_count++;
		advance_count  += predicted.advanced;
		complete_count += predicted.done;
		reject_count   += predicted.rejected;
		gap = idle_len(tx_quiet);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold until every predicted beat has come back;
	// optionally let the core run out its pipeline before a register write.
	task automatic settle_idle(input bit full);
		if (cmd_ch.valid)
			cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		if (full)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the write port is left quiet again before returning.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LOOP_ENABLE: shadow_loop   = value[0];
			REG_SPEED:       shadow_speed  = value[SPEED_W-1:0];
			REG_FRAME_TOTAL: shadow_total  = value[FRAME_W-1:0];
			REG_PERIOD:      shadow_period = value[PERIOD_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Reset defaults: zero frames, zero period, speed factor 128, no looping.
	task automatic test_reset_defaults();
		issue_command(ACT_TICK, 64'd5, '0);     // tick while stopped: nothing moves
		issue_command(ACT_PAUSE, 64'd6, '0);    // pause while stopped: rejected
		issue_command(ACT_START, 64'd100, '0);
		// Zero period elapses at once; empty animation stops on frame 0.
		issue_command(ACT_TICK, 64'd100, '0);
	endtask

	// Empty animation in loop mode wraps to frame 0; paused ticks do nothing.
	task automatic test_empty_animation();
		settle_idle(1'b1);
		write_reg(REG_LOOP_ENABLE, CFG_DATA_W'(1));
		issue_command(ACT_START, 64'd7, '0);
		issue_command(ACT_TICK, 64'd7, '0);
		issue_command(ACT_PAUSE, 64'd8, '0);
		issue_command(ACT_TICK, 64'd9, '0);
	endtask

	// Largest animation at the slowest speed: stop on the last frame, then
	// wrap from frame 65535 across a stamp wrap-around.
	task automatic test_frame_end();
		logic [TIME_W-1:0] span;
		settle_idle(1'b1);
		write_reg(REG_LOOP_ENABLE, CFG_DATA_W'(0));
		write_reg(REG_SPEED, CFG_DATA_W'(1));
		write_reg(REG_FRAME_TOTAL, CFG_DATA_W'(FRAME_LAST));
		write_reg(REG_PERIOD, PERIOD_MAX);
		span = frame_period_ticks();
		issue_command(ACT_START, '0, '0);
		issue_command(ACT_SEEK, 64'd1, FRAME_LAST - 1'b1);
		issue_command(ACT_TICK, span - 1'b1, '0);   // one short of the period
		issue_command(ACT_TICK, span, '0);          // reaches the end: completed
		issue_command(ACT_SEEK, span, FRAME_LAST);  // progress saturates
		settle_idle(1'b1);
		write_reg(REG_LOOP_ENABLE, CFG_DATA_W'(1));
		issue_command(ACT_START, WRAP_BASE, '0);
		issue_command(ACT_SEEK, WRAP_BASE, FRAME_LAST);
		// Elapsed time wraps modulo 2^64; the next frame would be 65536.
		issue_command(ACT_TICK, WRAP_BASE + span, '0);
	endtask

	// Zero speed plays as the slowest speed; seek past the end; undefined actions.
	task automatic test_speed_floor();
		logic [TIME_W-1:0] base;
		settle_idle(1'b1);
		write_reg(REG_LOOP_ENABLE, CFG_DATA_W'(0));
		write_reg(REG_SPEED, CFG_DATA_W'(0));
		write_reg(REG_PERIOD, CFG_DATA_W'(1));
		write_reg(REG_FRAME_TOTAL, CFG_DATA_W'(3));
		base = 64'd1000;
		issue_command(ACT_START, base, '0);
		issue_command(ACT_TICK, base + 64'd255, '0);   // period is 256 here
		issue_command(ACT_TICK, base + 64'd256, '0);
		issue_command(ACT_SEEK, base + 64'd257, FRAME_LAST);
		for (int k = 1; k <= 3; k++)
			issue_command(ACT_SEEK + 3'(k), base, FRAME_LAST);
		issue_command(ACT_STOP, base, '0);
	endtask

	// Random phases: reprogram, start, then mostly ticks aimed at the period.
	task automatic test_random_play();
		logic                  loop_v;
		logic [SPEED_W-1:0]    speed_v;
		logic [FRAME_W-1:0]    total_v;
		logic [PERIOD_W-1:0]   period_v;
		logic [TIME_W-1:0]     stamp;
		logic [TIME_W-1:0]     span;
		logic [FRAME_W-1:0]    target;
		int                    roll;
		int                    beats;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_idle(1'b1);
			case (phase)
				0: begin
					loop_v = 1'b0; speed_v = 8'd255; total_v = 16'd1; period_v = '0;
				end
				1: begin
					loop_v = 1'b1; speed_v = 8'd1; total_v = FRAME_LAST; period_v = PERIOD_MAX;
				end
				2: begin
					loop_v = 1'b1; speed_v = SPEED_RESET; total_v = '0; period_v = 24'd1000;
				end
				3: begin
					loop_v = 1'b0; speed_v = '0; total_v = 16'd5; period_v = 24'd3;
				end
				default: begin
					loop_v = 1'($urandom_range(0, 1));
					roll = $urandom_range(0, 99);
					speed_v = roll < 15 ? 8'd1 : roll < 30 ? 8'd255 : roll < 35 ? 8'd0 :
						8'($urandom_range(1, 255));
					roll = $urandom_range(0, 99);
					total_v = roll < 10 ? '0 : roll < 20 ? FRAME_LAST :
						roll < 30 ? 16'($urandom) : 16'($urandom_range(1, 12));
					roll = $urandom_range(0, 99);
					period_v = roll < 10 ? '0 : roll < 20 ? PERIOD_MAX :
						roll < 30 ? 24'($urandom) : 24'($urandom_range(1, 2000));
				end
			endcase
			write_reg(REG_LOOP_ENABLE, CFG_DATA_W'(loop_v));
			write_reg(REG_SPEED, CFG_DATA_W'(speed_v));
			write_reg(REG_FRAME_TOTAL, CFG_DATA_W'(total_v));
			write_reg(REG_PERIOD, period_v);
			// Run some phases with no idling on one side or the other.
			tx_quiet = (phase % 4 == 3);
			rx_quiet = (phase % 5 == 2);

			stamp = {$urandom, $urandom};
			issue_command(ACT_START, stamp, 16'($urandom));
			beats = 1;
			while (beats < PHASE_BEATS) begin
				roll = $urandom_range(0, 99);
				if (roll < 62) begin
					span = frame_period_ticks();
					if ($urandom_range(0, 1))
						stamp = shadow_last + span + 64'($urandom_range(0, 2)) - 64'd1;
					else
						stamp = stamp + ({$urandom, $urandom} % ((span >> 1) + 64'd1));
					issue_command(ACT_TICK, stamp, 16'($urandom));
				end else if (roll < 70) begin
					// Seek near the end in a third of cases, so stops and wraps come quickly.
					case ($urandom_range(0, 2))
						0: target = shadow_total - 16'($urandom_range(0, 2));
						1: target = 16'($urandom_range(0, shadow_total));
						default: target = 16'($urandom);
					endcase
					issue_command(ACT_SEEK, stamp, target);
				end else if (roll < 74) begin
					issue_command(ACT_PAUSE, stamp, 16'($urandom));
				end else if (roll < 78) begin
					issue_command(ACT_STOP, stamp, 16'($urandom));
				end else if (roll < 88) begin
					stamp = stamp + 64'($urandom_range(0, 5000));
					issue_command(ACT_START, stamp, 16'($urandom));
				end else if (roll < 92) begin
					issue_command(ACT_SEEK + 3'($urandom_range(1, 3)), {$urandom, $urandom},
						16'($urandom));
				end else if (roll < 97) begin
					// Stray stamp anywhere in the 64-bit range.
					issue_command(ACT_TICK, {$urandom, $urandom}, 16'($urandom));
				end else begin
					// Hold off the sender until every result has drained.
					settle_idle(1'b0);
					continue;
				end
				beats++;
			end
		end
	endtask

	// Result side: check each beat against the oldest prediction, stall at random.
	initial begin
		int          stall_left;
		seq_result_t want;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				result_count++;
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with nothing expected: status %0d frame %0d",
						$time, res_ch.play_status, res_ch.frame_pos);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("play_status", want.status, res_ch.play_status);
					check_field("frame_pos", want.frame, res_ch.frame_pos);
					check_field("frame_advanced", want.advanced, res_ch.frame_advanced);
					check_field("completed", want.done, res_ch.completed);
					check_field("rejected", want.rejected, res_ch.rejected);
					check_field("progress_percent", want.percent, res_ch.progress_percent);
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				stall_left = idle_len(rx_quiet);
				res_ch.ready <= (stall_left == 0);
			end
		end
	end

	// Sequence the tests.
	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_LOOP_ENABLE;
		cfg_wdata         <= '0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.action     <= ACT_TICK;
		cmd_ch.time_us    <= '0;
		cmd_ch.seek_frame <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_empty_animation();
		test_frame_end();
		test_speed_floor();
		test_random_play();

		// Drain, then give late or stray beats a chance to show up.
		settle_idle(1'b1);
		$display("ran %0d command beats: directed cases plus %0d random register phases",
			cmd_count, RANDOM_PHASES);
		$display("saw %0d result beats: %0d advances, %0d completions, %0d rejected pauses",
			result_count, advance_count, complete_count, reject_count);
		if (error_count == 0 && pending_results.size() == 0)
			$display("animation_frame_sequencer_core regression: pass");
		else
			$display("animation_frame_sequencer_core regression: fail");
		$finish;
	end

endmodule
